### sv/fdrt_pkg.sv
// Shared constants, configuration register codes and the configuration
// bundle for the frame damage rectangle tracker. No dependencies.
package fdrt_pkg;

    // Parameter defaults
    localparam int DEF_MAX_ROW_BYTES = 8192;
    localparam int DEF_MAX_ROWS      = 4096;
    localparam int DEF_MAX_RECTS     = 16;
    localparam int QUEUE_DEPTH       = 4;

    // Register and port widths
    localparam int ROW_BYTES_W   = 14;
    localparam int PIXEL_BYTES_W = 3;
    localparam int FRAME_ROWS_W  = 13;
    localparam int BAND_FLAGS_W  = 2;
    localparam int BAND_ROW_W    = 13;
    localparam int CFG_DATA_W    = 14;
    localparam int CFG_IDX_W     = 3;
    localparam int BYTE_W        = 8;
    localparam int LEFT_W        = 14;
    localparam int RIGHT_W       = 14;
    localparam int TOP_W         = 12;
    localparam int BOTTOM_W      = 13;
    localparam int MAX_PIX_BYTES = 4;

    localparam int BAND_CLIP_BIT = 0;
    localparam int BAND_ANIM_BIT = 1;

    // Reset values
    localparam logic [ROW_BYTES_W-1:0]   RST_ROW_BYTES   = ROW_BYTES_W'(4096);
    localparam logic [PIXEL_BYTES_W-1:0] RST_PIXEL_BYTES = PIXEL_BYTES_W'(4);
    localparam logic [FRAME_ROWS_W-1:0]  RST_FRAME_ROWS  = FRAME_ROWS_W'(768);
    localparam logic [BAND_FLAGS_W-1:0]  RST_BAND_FLAGS  = '0;
    localparam logic [BAND_ROW_W-1:0]    RST_CLIP_TOP    = '0;
    localparam logic [BAND_ROW_W-1:0]    RST_CLIP_BOTTOM = BAND_ROW_W'(4096);
    localparam logic [BAND_ROW_W-1:0]    RST_ANIM_TOP    = '0;
    localparam logic [BAND_ROW_W-1:0]    RST_ANIM_BOTTOM = '0;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ROW_BYTES   = 3'd0,
        REG_PIXEL_BYTES = 3'd1,
        REG_FRAME_ROWS  = 3'd2,
        REG_BAND_FLAGS  = 3'd3,
        REG_CLIP_TOP    = 3'd4,
        REG_CLIP_BOTTOM = 3'd5,
        REG_ANIM_TOP    = 3'd6,
        REG_ANIM_BOTTOM = 3'd7
    } cfg_reg_t;

    typedef struct packed {
        logic [ROW_BYTES_W-1:0]   row_bytes;
        logic [PIXEL_BYTES_W-1:0] pixel_bytes;
        logic [FRAME_ROWS_W-1:0]  frame_rows;
        logic [BAND_FLAGS_W-1:0]  band_flags;
        logic [BAND_ROW_W-1:0]    clip_top;
        logic [BAND_ROW_W-1:0]    clip_bottom;
        logic [BAND_ROW_W-1:0]    anim_top;
        logic [BAND_ROW_W-1:0]    anim_bottom;
    } cfg_t;

endpackage

### sv/fdrt_queue.sv
// Small valid/ready FIFO between the row classifier and the rectangle merger.
// Generic over data width and depth; no package dependency.
module fdrt_queue #(
    parameter int W     = 8,
    parameter int DEPTH = 4
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         in_valid,
    output logic         in_ready,
    input  logic [W-1:0] in_data,
    output logic         out_valid,
    input  logic         out_ready,
    output logic [W-1:0] out_data
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [W-1:0]     slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             push, pop;

    assign in_ready  = (cnt_reg != CNT_W'(DEPTH));
    assign out_valid = (cnt_reg != '0);
    assign out_data  = slot_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop) begin
            cnt_next = cnt_reg + CNT_W'(1);
        end else if (pop && !push) begin
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= in_data;
        end
    end

endmodule

### sv/fdrt_front.sv
// Front end: counts byte/pixel/row position, tracks per-row damage span and
// band membership, and pushes one row record per row. Uses fdrt_pkg.
module fdrt_front #(
    parameter  int MAX_ROW_BYTES = 8192,
    parameter  int MAX_ROWS      = 4096,
    localparam int COL_W         = $clog2(MAX_ROW_BYTES),
    localparam int ROW_W         = $clog2(MAX_ROWS),
    localparam int REC_W         = ROW_W + 2 * COL_W + 3
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  fdrt_pkg::cfg_t       cfg,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [7:0]           s_new_byte,
    input  logic [7:0]           s_old_byte,
    input  logic                 s_force_all,
    output logic                 rec_valid,
    input  logic                 rec_ready,
    output logic [REC_W-1:0]     rec_data
);
    import fdrt_pkg::*;

    localparam int RB_W  = (COL_W + 1 > ROW_BYTES_W) ? COL_W + 1 : ROW_BYTES_W;
    localparam int NR_W  = (ROW_W + 1 > FRAME_ROWS_W) ? ROW_W + 1 : FRAME_ROWS_W;
    localparam int CMP_W = (ROW_W > BAND_ROW_W) ? ROW_W : BAND_ROW_W;

    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic             damaged;
        logic [COL_W-1:0] left;
        logic [COL_W:0]   right;
        logic             frame_end;
    } row_rec_t;

    logic [COL_W-1:0] byte_col_reg, byte_col_next;
    logic [COL_W-1:0] pix_col_reg, pix_col_next;
    logic [1:0]       bip_reg, bip_next;
    logic [ROW_W-1:0] row_idx_reg, row_idx_next;
    logic             row_changed_reg, row_forced_reg;
    logic [COL_W-1:0] first_reg, last_reg;

    logic [RB_W-1:0]          rb_raw, rb_lim;
    logic [PIXEL_BYTES_W-1:0] bpp_lim;
    logic [NR_W-1:0]          nr_raw, rows_lim;
    logic [CMP_W-1:0]         row_c;
    logic                     row_end, pix_end, frame_end;
    logic                     in_clip, in_anim, in_band;
    logic                     col0, diff, forced_eff, changed_eff;
    logic [COL_W-1:0]         first_eff, last_eff;
    logic                     accept;
    row_rec_t                 rec;

    always_comb begin
        // effective sizes: zero acts as one, oversize clamps
        rb_raw = RB_W'(cfg.row_bytes);
        if (cfg.row_bytes == '0) begin
            rb_lim = RB_W'(1);
        end else if (rb_raw > RB_W'(MAX_ROW_BYTES)) begin
            rb_lim = RB_W'(MAX_ROW_BYTES);
        end else begin
            rb_lim = rb_raw;
        end

        if (cfg.pixel_bytes == '0) begin
            bpp_lim = PIXEL_BYTES_W'(1);
        end else if (cfg.pixel_bytes > PIXEL_BYTES_W'(MAX_PIX_BYTES)) begin
            bpp_lim = PIXEL_BYTES_W'(MAX_PIX_BYTES);
        end else begin
            bpp_lim = cfg.pixel_bytes;
        end

        nr_raw = NR_W'(cfg.frame_rows);
        if (cfg.frame_rows == '0) begin
            rows_lim = NR_W'(1);
        end else if (nr_raw > NR_W'(MAX_ROWS)) begin
            rows_lim = NR_W'(MAX_ROWS);
        end else begin
            rows_lim = nr_raw;
        end

        row_end   = (RB_W'(byte_col_reg) + RB_W'(1)) >= rb_lim;
        pix_end   = (PIXEL_BYTES_W'(bip_reg) + PIXEL_BYTES_W'(1)) >= bpp_lim;
        frame_end = (NR_W'(row_idx_reg) + NR_W'(1)) >= rows_lim;

        row_c   = CMP_W'(row_idx_reg);
        in_clip = (row_c >= CMP_W'(cfg.clip_top)) && (row_c < CMP_W'(cfg.clip_bottom));
        in_anim = cfg.band_flags[BAND_ANIM_BIT] && (row_c >= CMP_W'(cfg.anim_top))
                  && (row_c < CMP_W'(cfg.anim_bottom));
        in_band = !cfg.band_flags[BAND_CLIP_BIT] || in_clip || in_anim;

        // row state as seen with this byte included
        col0        = (byte_col_reg == '0);
        diff        = (s_new_byte != s_old_byte);
        forced_eff  = col0 ? s_force_all : row_forced_reg;
        changed_eff = (!col0 && row_changed_reg) || diff;
        first_eff   = (diff && (col0 || !row_changed_reg)) ? pix_col_reg : first_reg;
        last_eff    = diff ? pix_col_reg : last_reg;

        rec.row       = row_idx_reg;
        rec.damaged   = forced_eff || (in_band && changed_eff);
        rec.left      = forced_eff ? '0 : first_eff;
        rec.right     = forced_eff ? ({1'b0, pix_col_reg} + (COL_W + 1)'(1))
                                   : ({1'b0, last_eff} + (COL_W + 1)'(1));
        rec.frame_end = frame_end;
    end

    assign s_ready   = rec_ready || !row_end;
    assign rec_valid = s_valid && row_end;
    assign rec_data  = rec;
    assign accept    = s_valid && s_ready;

    always_comb begin
        byte_col_next = byte_col_reg;
        pix_col_next  = pix_col_reg;
        bip_next      = bip_reg;
        row_idx_next  = row_idx_reg;
        if (row_end) begin
            byte_col_next = '0;
            pix_col_next  = '0;
            bip_next      = '0;
            row_idx_next  = frame_end ? '0 : row_idx_reg + ROW_W'(1);
        end else begin
            byte_col_next = byte_col_reg + COL_W'(1);
            if (pix_end) begin
                bip_next     = '0;
                pix_col_next = pix_col_reg + COL_W'(1);
            end else begin
                bip_next = bip_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_col_reg    <= '0;
            pix_col_reg     <= '0;
            bip_reg         <= '0;
            row_idx_reg     <= '0;
            row_changed_reg <= 1'b0;
            row_forced_reg  <= 1'b0;
            first_reg       <= '0;
            last_reg        <= '0;
        end else if (accept) begin
            byte_col_reg    <= byte_col_next;
            pix_col_reg     <= pix_col_next;
            bip_reg         <= bip_next;
            row_idx_reg     <= row_idx_next;
            row_changed_reg <= changed_eff;
            row_forced_reg  <= forced_eff;
            first_reg       <= first_eff;
            last_reg        <= last_eff;
        end
    end

endmodule

### sv/fdrt_back.sv
// Back end: merges row records into rectangles, keeps closed rectangles in a
// small memory and emits them at frame end. Uses fdrt_pkg.
module fdrt_back #(
    parameter  int MAX_ROW_BYTES = 8192,
    parameter  int MAX_ROWS      = 4096,
    parameter  int MAX_RECTS     = 16,
    localparam int COL_W         = $clog2(MAX_ROW_BYTES),
    localparam int ROW_W         = $clog2(MAX_ROWS),
    localparam int REC_W         = ROW_W + 2 * COL_W + 3
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          rec_valid,
    output logic                          rec_ready,
    input  logic [REC_W-1:0]              rec_data,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [fdrt_pkg::LEFT_W-1:0]   m_rect_left,
    output logic [fdrt_pkg::RIGHT_W-1:0]  m_rect_right,
    output logic [fdrt_pkg::TOP_W-1:0]    m_rect_top,
    output logic [fdrt_pkg::BOTTOM_W-1:0] m_rect_bottom,
    output logic                          m_rect_valid,
    output logic                          m_last_rect
);
    import fdrt_pkg::*;

    localparam int CNT_W = $clog2(MAX_RECTS + 1);
    localparam int IDX_W = (MAX_RECTS > 1) ? $clog2(MAX_RECTS) : 1;

    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic             damaged;
        logic [COL_W-1:0] left;
        logic [COL_W:0]   right;
        logic             frame_end;
    } row_rec_t;

    typedef struct packed {
        logic [COL_W-1:0] left;
        logic [COL_W:0]   right;
        logic [ROW_W-1:0] top;
        logic [ROW_W:0]   bottom;
    } rect_t;

    typedef enum logic [3:0] {
        ST_RUN  = 4'b0001,
        ST_RD   = 4'b0010,
        ST_PUT  = 4'b0100,
        ST_LAST = 4'b1000
    } back_state_t;

    back_state_t      state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             run_open_reg, run_open_next;
    rect_t            cur_reg, cur_next;
    logic [IDX_W-1:0] emit_idx_reg, emit_idx_next;
    rect_t            out_rect_reg, out_rect_next;
    logic             out_flag_reg, out_flag_next;
    logic             out_last_reg, out_last_next;
    logic             m_valid_reg, m_valid_next;

    rect_t            rect_mem [MAX_RECTS];
    rect_t            rd_data_reg;
    logic             wr_en, rd_en;
    logic [IDX_W-1:0] wr_addr, rd_addr;
    logic [CNT_W-1:0] cnt_m1;

    row_rec_t         rec;
    logic             pop, out_free, put_done;
    logic [ROW_W:0]   bottom_new;

    assign rec       = row_rec_t'(rec_data);
    assign rec_ready = (state_reg == ST_RUN);
    assign pop       = rec_valid && rec_ready;
    assign out_free  = !m_valid_reg || m_ready;
    assign cnt_m1    = cnt_reg - CNT_W'(1);
    assign wr_addr   = cnt_m1[IDX_W-1:0];
    assign bottom_new = {1'b0, rec.row} + (ROW_W + 1)'(1);
    // last stored entry is index count-2; the open one sits in cur_reg
    assign put_done  = ((CNT_W + 1)'(emit_idx_reg) + (CNT_W + 1)'(2))
                       == (CNT_W + 1)'(cnt_reg);

    always_comb begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        run_open_next = run_open_reg;
        cur_next      = cur_reg;
        emit_idx_next = emit_idx_reg;
        out_rect_next = out_rect_reg;
        out_flag_next = out_flag_reg;
        out_last_next = out_last_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        wr_en         = 1'b0;
        rd_en         = 1'b0;
        rd_addr       = emit_idx_reg;

        case (state_reg)
            ST_RUN: begin
                if (pop) begin
                    if (rec.damaged) begin
                        if (!run_open_reg && (cnt_reg < CNT_W'(MAX_RECTS))) begin
                            wr_en           = (cnt_reg != '0);
                            cur_next.left   = rec.left;
                            cur_next.right  = rec.right;
                            cur_next.top    = rec.row;
                            cur_next.bottom = bottom_new;
                            cnt_next        = cnt_reg + CNT_W'(1);
                        end else if (cnt_reg != '0) begin
                            if (rec.left < cur_reg.left) begin
                                cur_next.left = rec.left;
                            end
                            if (rec.right > cur_reg.right) begin
                                cur_next.right = rec.right;
                            end
                            cur_next.bottom = bottom_new;
                        end
                        run_open_next = 1'b1;
                    end else begin
                        run_open_next = 1'b0;
                    end
                    if (rec.frame_end) begin
                        run_open_next = 1'b0;
                        emit_idx_next = '0;
                        state_next    = ((CNT_W + 1)'(cnt_next) >= (CNT_W + 1)'(2))
                                        ? ST_RD : ST_LAST;
                    end
                end
            end
            ST_RD: begin
                rd_en      = 1'b1;
                state_next = ST_PUT;
            end
            ST_PUT: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    out_rect_next = rd_data_reg;
                    out_flag_next = 1'b1;
                    out_last_next = 1'b0;
                    if (put_done) begin
                        state_next = ST_LAST;
                    end else begin
                        emit_idx_next = emit_idx_reg + IDX_W'(1);
                        rd_en         = 1'b1;
                        rd_addr       = emit_idx_reg + IDX_W'(1);
                    end
                end
            end
            ST_LAST: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    out_rect_next = (cnt_reg != '0) ? cur_reg : '0;
                    out_flag_next = (cnt_reg != '0);
                    out_last_next = 1'b1;
                    cnt_next      = '0;
                    state_next    = ST_RUN;
                end
            end
            default: begin
                state_next = ST_RUN;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_RUN;
            cnt_reg      <= '0;
            run_open_reg <= 1'b0;
            emit_idx_reg <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            run_open_reg <= run_open_next;
            emit_idx_reg <= emit_idx_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cur_reg      <= cur_next;
        out_rect_reg <= out_rect_next;
        out_flag_reg <= out_flag_next;
        out_last_reg <= out_last_next;
    end

    // closed rectangles; the open one stays in cur_reg
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            rect_mem[wr_addr] <= cur_reg;
        end
        if (rd_en) begin
            rd_data_reg <= rect_mem[rd_addr];
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_rect_left   = LEFT_W'(out_rect_reg.left);
    assign m_rect_right  = RIGHT_W'(out_rect_reg.right);
    assign m_rect_top    = TOP_W'(out_rect_reg.top);
    assign m_rect_bottom = BOTTOM_W'(out_rect_reg.bottom);
    assign m_rect_valid  = out_flag_reg;
    assign m_last_rect   = out_last_reg;

endmodule

### sv/frame_damage_rect_tracker.sv
// Frame damage rectangle tracker: top level with configuration registers,
// front end, row queue and back end. Uses fdrt_pkg, fdrt_front, fdrt_queue, fdrt_back.
//
// Usage:
//  - Input channel (s_*): one item per byte of the frame in raster order, new
//    byte, previous-frame byte and force_all (looked at on a row's first byte).
//    Accepted when s_valid and s_ready are high at a clock edge.
//  - Result channel (m_*): at frame end, one item per damage rectangle, in
//    order of rows, with m_last_rect on the final one; a frame with no damage
//    gives one item with m_rect_valid low.
//  - Config port: cfg_wr_en writes cfg_wr_data into register cfg_wr_index on
//    the clock edge, no wait. Write only while the block is idle.
//  - Throughput: one byte per cycle while the back end keeps up: it takes row
//    records while running but none while it emits a frame's results, so
//    only very short frames run slower and back up through the 4-entry queue.
//  - Latency: a frame's first result passes the row queue, the rectangle
//    memory read (skipped with at most one rectangle) and the result register;
//    later ones follow one per cycle while m_ready is high (single read port).
//  - While results drain, the back end takes no row records; the queue lets
//    the front end keep taking bytes until four rows have finished.
//  - A stalled receiver holds the result register; the stall reaches the
//    input only once the queue is full.
//  - Synchronous reset (aresetn low) clears counters, queue and output valid, reloads registers.
module frame_damage_rect_tracker #(
    parameter int MAX_ROW_BYTES = fdrt_pkg::DEF_MAX_ROW_BYTES,
    parameter int MAX_ROWS      = fdrt_pkg::DEF_MAX_ROWS,
    parameter int MAX_RECTS     = fdrt_pkg::DEF_MAX_RECTS
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // configuration write port
    input  logic                            cfg_wr_en,
    input  logic [fdrt_pkg::CFG_IDX_W-1:0]  cfg_wr_index,
    input  logic [fdrt_pkg::CFG_DATA_W-1:0] cfg_wr_data,
    // byte stream
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [fdrt_pkg::BYTE_W-1:0]     s_new_byte,
    input  logic [fdrt_pkg::BYTE_W-1:0]     s_old_byte,
    input  logic                            s_force_all,
    // rectangles
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [fdrt_pkg::LEFT_W-1:0]     m_rect_left,
    output logic [fdrt_pkg::RIGHT_W-1:0]    m_rect_right,
    output logic [fdrt_pkg::TOP_W-1:0]      m_rect_top,
    output logic [fdrt_pkg::BOTTOM_W-1:0]   m_rect_bottom,
    output logic                            m_rect_valid,
    output logic                            m_last_rect
);
    import fdrt_pkg::*;

    localparam int COL_W = $clog2(MAX_ROW_BYTES);
    localparam int ROW_W = $clog2(MAX_ROWS);
    localparam int REC_W = ROW_W + 2 * COL_W + 3;

    cfg_t cfg_reg;

    logic             fr_valid, fr_ready;
    logic [REC_W-1:0] fr_data;
    logic             bk_valid, bk_ready;
    logic [REC_W-1:0] bk_data;

    // configuration registers, each masked to its width
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.row_bytes   <= RST_ROW_BYTES;
            cfg_reg.pixel_bytes <= RST_PIXEL_BYTES;
            cfg_reg.frame_rows  <= RST_FRAME_ROWS;
            cfg_reg.band_flags  <= RST_BAND_FLAGS;
            cfg_reg.clip_top    <= RST_CLIP_TOP;
            cfg_reg.clip_bottom <= RST_CLIP_BOTTOM;
            cfg_reg.anim_top    <= RST_ANIM_TOP;
            cfg_reg.anim_bottom <= RST_ANIM_BOTTOM;
        end else if (cfg_wr_en) begin
            case (cfg_reg_t'(cfg_wr_index))
                REG_ROW_BYTES:   cfg_reg.row_bytes   <= cfg_wr_data[ROW_BYTES_W-1:0];
                REG_PIXEL_BYTES: cfg_reg.pixel_bytes <= cfg_wr_data[PIXEL_BYTES_W-1:0];
                REG_FRAME_ROWS:  cfg_reg.frame_rows  <= cfg_wr_data[FRAME_ROWS_W-1:0];
                REG_BAND_FLAGS:  cfg_reg.band_flags  <= cfg_wr_data[BAND_FLAGS_W-1:0];
                REG_CLIP_TOP:    cfg_reg.clip_top    <= cfg_wr_data[BAND_ROW_W-1:0];
                REG_CLIP_BOTTOM: cfg_reg.clip_bottom <= cfg_wr_data[BAND_ROW_W-1:0];
                REG_ANIM_TOP:    cfg_reg.anim_top    <= cfg_wr_data[BAND_ROW_W-1:0];
                REG_ANIM_BOTTOM: cfg_reg.anim_bottom <= cfg_wr_data[BAND_ROW_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // byte counting and per-row classification
    fdrt_front #(
        .MAX_ROW_BYTES (MAX_ROW_BYTES),
        .MAX_ROWS      (MAX_ROWS)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg_reg),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_new_byte  (s_new_byte),
        .s_old_byte  (s_old_byte),
        .s_force_all (s_force_all),
        .rec_valid   (fr_valid),
        .rec_ready   (fr_ready),
        .rec_data    (fr_data)
    );

    // row records wait here while the back end emits a frame
    fdrt_queue #(
        .W     (REC_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (fr_valid),
        .in_ready  (fr_ready),
        .in_data   (fr_data),
        .out_valid (bk_valid),
        .out_ready (bk_ready),
        .out_data  (bk_data)
    );

    // run merging, rectangle store and result output
    fdrt_back #(
        .MAX_ROW_BYTES (MAX_ROW_BYTES),
        .MAX_ROWS      (MAX_ROWS),
        .MAX_RECTS     (MAX_RECTS)
    ) u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .rec_valid     (bk_valid),
        .rec_ready     (bk_ready),
        .rec_data      (bk_data),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_rect_left   (m_rect_left),
        .m_rect_right  (m_rect_right),
        .m_rect_top    (m_rect_top),
        .m_rect_bottom (m_rect_bottom),
        .m_rect_valid  (m_rect_valid),
        .m_last_rect   (m_last_rect)
    );

endmodule

### dv/tb_top.sv
`timescale 1ns / 100ps
// Self-checking bench for frame_damage_rect_tracker: random and directed frames,
// a cycle-free damage predictor and an in-order rectangle checker.
// Depends on fdrt_pkg and the frame_damage_rect_tracker RTL.
module tb_top;
    import fdrt_pkg::*;

    localparam int CLK_PERIOD    = 10;
    localparam int MAX_RECTS     = DEF_MAX_RECTS;
    localparam int SETTLE_CYCLES = 24;     // result latency plus the 4-row queue, with margin
    localparam int HOLD_CYCLES   = 400;
    localparam int RANDOM_ITEMS  = 240;
    localparam int TIMEOUT_NS    = 5_000_000;

    // one byte of the frame stream
    typedef struct {
        logic [BYTE_W-1:0] cur_val;
        logic [BYTE_W-1:0] prev_val;
        logic              frc;
    } byte_item_t;

    // one rectangle result, field order matches the m_* ports
    typedef struct packed {
        logic [LEFT_W-1:0]   left;
        logic [RIGHT_W-1:0]  right;
        logic [TOP_W-1:0]    top;
        logic [BOTTOM_W-1:0] bottom;
        logic                valid;
        logic                last;
    } damage_rect_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_wr_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wr_data = '0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    logic [BYTE_W-1:0]     s_new_byte = '0;
    logic [BYTE_W-1:0]     s_old_byte = '0;
    logic                  s_force_all = 1'b0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic [LEFT_W-1:0]     m_rect_left;
    logic [RIGHT_W-1:0]    m_rect_right;
    logic [TOP_W-1:0]      m_rect_top;
    logic [BOTTOM_W-1:0]   m_rect_bottom;
    logic                  m_rect_valid;
    logic                  m_last_rect;

    frame_damage_rect_tracker u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_index  (cfg_wr_index),
        .cfg_wr_data   (cfg_wr_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_new_byte    (s_new_byte),
        .s_old_byte    (s_old_byte),
        .s_force_all   (s_force_all),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_rect_left   (m_rect_left),
        .m_rect_right  (m_rect_right),
        .m_rect_top    (m_rect_top),
        .m_rect_bottom (m_rect_bottom),
        .m_rect_valid  (m_rect_valid),
        .m_last_rect   (m_last_rect)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    // ------------------------------------------------------------------
    // Bench state
    // ------------------------------------------------------------------
    byte_item_t   pending_bytes[$];     // filled by the sequence, drained by the driver
    damage_rect_t expected_rects[$];    // predicted results, oldest first
    byte_item_t   next_byte;
    damage_rect_t got_rect;
    damage_rect_t want_rect;

    int unsigned send_idle_pct = 35;
    int unsigned recv_idle_pct = 76;
    logic        hold_go = 1'b0;
    int unsigned hold_left = 0;

    int unsigned error_count     = 0;
    int unsigned items_queued    = 0;
    int unsigned bytes_taken     = 0;
    int unsigned rects_predicted = 0;
    int unsigned rects_checked   = 0;
    int unsigned settings_used   = 0;

    // ------------------------------------------------------------------
    // Damage predictor: own copy of the registers and the row/frame state
    // ------------------------------------------------------------------
    cfg_t                   regs_shadow;
    logic [12:0]            byte_col;
    logic [12:0]            pix_col;
    logic [1:0]             byte_in_px;
    logic [11:0]            row_idx;
    logic                   row_changed;
    logic                   row_forced;
    logic                   run_open;
    logic [12:0]            first_px;
    logic [12:0]            last_px;
    logic [4:0]             rect_cnt;
    damage_rect_t           open_rects[MAX_RECTS];

    // zero acts as one, anything past the cap acts as the cap
    function automatic int unsigned fit_size(input int unsigned v, input int unsigned hi);
        if (v == 0) return 1;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic cfg_t make_cfg(input int unsigned rb, input int unsigned pb,
                                      input int unsigned fr, input int unsigned flags,
                                      input int unsigned ct, input int unsigned cb,
                                      input int unsigned at, input int unsigned ab);
        cfg_t c;
        c.row_bytes   = ROW_BYTES_W'(rb);
        c.pixel_bytes = PIXEL_BYTES_W'(pb);
        c.frame_rows  = FRAME_ROWS_W'(fr);
        c.band_flags  = BAND_FLAGS_W'(flags);
        c.clip_top    = BAND_ROW_W'(ct);
        c.clip_bottom = BAND_ROW_W'(cb);
        c.anim_top    = BAND_ROW_W'(at);
        c.anim_bottom = BAND_ROW_W'(ab);
        return c;
    endfunction

    function automatic void clear_tracker();
        regs_shadow = make_cfg(RST_ROW_BYTES, RST_PIXEL_BYTES, RST_FRAME_ROWS, RST_BAND_FLAGS,
                               RST_CLIP_TOP, RST_CLIP_BOTTOM, RST_ANIM_TOP, RST_ANIM_BOTTOM);
        byte_col    = '0;
        pix_col     = '0;
        byte_in_px  = '0;
        row_idx     = '0;
        row_changed = 1'b0;
        row_forced  = 1'b0;
        run_open    = 1'b0;
        first_px    = '0;
        last_px     = '0;
        rect_cnt    = '0;
    endfunction

    // Row end: decide damage, then open a new rectangle or widen the current one.
    // Past MAX_RECTS every damaged row lands in the last rectangle.
    function automatic void close_damage_row(input int unsigned width);
        logic        in_clip;
        logic        in_anim;
        logic        in_band;
        int unsigned x0;
        int unsigned x1;
        in_clip = row_idx >= regs_shadow.clip_top && row_idx < regs_shadow.clip_bottom;
        in_anim = regs_shadow.band_flags[BAND_ANIM_BIT] &&
                  row_idx >= regs_shadow.anim_top && row_idx < regs_shadow.anim_bottom;
        in_band = !regs_shadow.band_flags[BAND_CLIP_BIT] || in_clip || in_anim;
        if (!(row_forced || (in_band && row_changed))) begin
            run_open = 1'b0;
            return;
        end
        x0 = row_forced ? 0 : first_px;
        x1 = row_forced ? width : last_px + 1;
        if (!run_open && rect_cnt < MAX_RECTS) begin
            open_rects[rect_cnt].left   = LEFT_W'(x0);
            open_rects[rect_cnt].right  = RIGHT_W'(x1);
            open_rects[rect_cnt].top    = TOP_W'(row_idx);
            open_rects[rect_cnt].bottom = BOTTOM_W'(row_idx + 1);
            rect_cnt++;
        end else if (rect_cnt > 0) begin
            if (x0 < open_rects[rect_cnt-1].left)  open_rects[rect_cnt-1].left  = LEFT_W'(x0);
            if (x1 > open_rects[rect_cnt-1].right) open_rects[rect_cnt-1].right = RIGHT_W'(x1);
            open_rects[rect_cnt-1].bottom = BOTTOM_W'(row_idx + 1);
        end
        run_open = 1'b1;
    endfunction

    // Frame end: one result per rectangle, or a single empty one.
    function automatic void flush_frame_rects();
        damage_rect_t r;
        if (rect_cnt == 0) begin
            r      = '0;
            r.last = 1'b1;
            expected_rects.push_back(r);
            rects_predicted++;
        end else begin
            for (int k = 0; k < rect_cnt; k++) begin
                r       = open_rects[k];
                r.valid = 1'b1;
                r.last  = (k + 1 == rect_cnt);
                expected_rects.push_back(r);
                rects_predicted++;
            end
        end
    endfunction

    // Advance the predictor by one accepted byte.
    function automatic void track_byte(input byte_item_t it);
        int unsigned rb;
        int unsigned bpp;
        int unsigned rows;
        rb   = fit_size(regs_shadow.row_bytes, DEF_MAX_ROW_BYTES);
        bpp  = fit_size(regs_shadow.pixel_bytes, MAX_PIX_BYTES);
        rows = fit_size(regs_shadow.frame_rows, DEF_MAX_ROWS);
        // force is only looked at on the row's first byte
        if (byte_col == 0) begin
            row_forced  = it.frc;
            row_changed = 1'b0;
        end
        if (it.cur_val != it.prev_val) begin
            if (!row_changed) first_px = pix_col;
            last_px     = pix_col;
            row_changed = 1'b1;
        end
        // compare with >= so that a shrunk limit ends the row or frame at once
        if (byte_col + 1 >= rb) begin
            close_damage_row(pix_col + 1);
            byte_col   = '0;
            pix_col    = '0;
            byte_in_px = '0;
            if (row_idx + 1 >= rows) begin
                flush_frame_rects();
                row_idx     = '0;
                rect_cnt    = '0;
                run_open    = 1'b0;
                row_changed = 1'b0;
                row_forced  = 1'b0;
            end else begin
                row_idx++;
            end
        end else begin
            byte_col++;
            if (byte_in_px + 1 >= bpp) begin
                byte_in_px = '0;
                pix_col++;
            end else begin
                byte_in_px++;
            end
        end
    endfunction

    // ------------------------------------------------------------------
    // Driver: byte stream with random gaps, prediction on acceptance
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                track_byte('{s_new_byte, s_old_byte, s_force_all});
                bytes_taken++;
            end
            // only move on once the current item has gone (or nothing is offered)
            if (!s_valid || s_ready) begin
                if (pending_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    next_byte   = pending_bytes.pop_front();
                    s_valid     <= 1'b1;
                    s_new_byte  <= next_byte.cur_val;
                    s_old_byte  <= next_byte.prev_val;
                    s_force_all <= next_byte.frc;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Long receiver hold-off, counted down here so the sequence keeps feeding bytes.
    always @(posedge aclk) begin
        if (!aresetn) begin
            hold_left <= 0;
        end else if (hold_go) begin
            hold_left <= HOLD_CYCLES;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= hold_left == 0 && !hold_go && $urandom_range(99) >= recv_idle_pct;
        end
    end

    // ------------------------------------------------------------------
    // Monitor and checker
    // ------------------------------------------------------------------
    function automatic string rect_text(input damage_rect_t r);
        return $sformatf("L=%0d R=%0d T=%0d B=%0d valid=%0b last=%0b",
                         r.left, r.right, r.top, r.bottom, r.valid, r.last);
    endfunction

    function automatic void log_error(input string msg);
        error_count++;
        if (error_count <= 10) $display("ERROR @%0t: %s", $realtime, msg);
    endfunction

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            got_rect = {m_rect_left, m_rect_right, m_rect_top, m_rect_bottom,
                        m_rect_valid, m_last_rect};
            if (expected_rects.size() == 0) begin
                log_error($sformatf("rect with nothing expected: %s", rect_text(got_rect)));
            end else begin
                want_rect = expected_rects.pop_front();
                if (got_rect !== want_rect)
                    log_error($sformatf("rect %0d expected %s got %s", rects_checked,
                                        rect_text(want_rect), rect_text(got_rect)));
            end
            rects_checked++;
        end
    end

    // ------------------------------------------------------------------
    // Sequence helpers
    // ------------------------------------------------------------------
    task automatic push_byte(input logic [BYTE_W-1:0] cur, input logic [BYTE_W-1:0] prev,
                             input logic frc);
        pending_bytes.push_back('{cur, prev, frc});
        items_queued++;
    endtask

    // one row; chg_pct is the chance per byte of differing from the old frame,
    // force only matters on byte 0 so the rest carry random force bits
    task automatic queue_row(input int unsigned nbytes, input logic frc,
                             input int unsigned chg_pct);
        logic [BYTE_W-1:0] cur;
        logic [BYTE_W-1:0] prev;
        for (int unsigned b = 0; b < nbytes; b++) begin
            cur  = BYTE_W'($urandom);
            prev = ($urandom_range(99) < chg_pct) ? cur ^ BYTE_W'($urandom_range(1, 255)) : cur;
            push_byte(cur, prev, (b == 0) ? frc : logic'($urandom_range(1)));
        end
    endtask

    // sender pauses until the block has drained and settled
    task automatic wait_idle();
        do @(negedge aclk);
        while (pending_bytes.size() != 0 || s_valid || expected_rects.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input int unsigned val);
        logic [CFG_DATA_W-1:0] data;
        data = CFG_DATA_W'(val);
        @(posedge aclk);
        cfg_wr_en    <= 1'b1;
        cfg_wr_index <= idx;
        cfg_wr_data  <= data;
        case (idx)
            REG_ROW_BYTES:   regs_shadow.row_bytes   = data[ROW_BYTES_W-1:0];
            REG_PIXEL_BYTES: regs_shadow.pixel_bytes = data[PIXEL_BYTES_W-1:0];
            REG_FRAME_ROWS:  regs_shadow.frame_rows  = data[FRAME_ROWS_W-1:0];
            REG_BAND_FLAGS:  regs_shadow.band_flags  = data[BAND_FLAGS_W-1:0];
            REG_CLIP_TOP:    regs_shadow.clip_top    = data[BAND_ROW_W-1:0];
            REG_CLIP_BOTTOM: regs_shadow.clip_bottom = data[BAND_ROW_W-1:0];
            REG_ANIM_TOP:    regs_shadow.anim_top    = data[BAND_ROW_W-1:0];
            REG_ANIM_BOTTOM: regs_shadow.anim_bottom = data[BAND_ROW_W-1:0];
            default: ;
        endcase
    endtask

    task automatic end_writes();
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic apply_config(input cfg_t c);
        write_reg(REG_ROW_BYTES,   c.row_bytes);
        write_reg(REG_PIXEL_BYTES, c.pixel_bytes);
        write_reg(REG_FRAME_ROWS,  c.frame_rows);
        write_reg(REG_BAND_FLAGS,  c.band_flags);
        write_reg(REG_CLIP_TOP,    c.clip_top);
        write_reg(REG_CLIP_BOTTOM, c.clip_bottom);
        write_reg(REG_ANIM_TOP,    c.anim_top);
        write_reg(REG_ANIM_BOTTOM, c.anim_bottom);
        end_writes();
        settings_used++;
    endtask

    // small frames keep results frequent; band edges sometimes at the extremes
    function automatic cfg_t random_cfg();
        cfg_t c;
        c = make_cfg($urandom_range(0, 6), $urandom_range(0, 7), $urandom_range(0, 8),
                     $urandom_range(0, 3), $urandom_range(0, 6), $urandom_range(0, 9),
                     $urandom_range(0, 6), $urandom_range(0, 9));
        if ($urandom_range(5) == 0) c.clip_bottom = '1;
        if ($urandom_range(5) == 0) c.anim_bottom = '1;
        if ($urandom_range(7) == 0) c.clip_top = '1;
        return c;
    endfunction

    task automatic queue_random_frame();
        int unsigned rb;
        int unsigned rows;
        int unsigned pct;
        rb   = fit_size(regs_shadow.row_bytes, DEF_MAX_ROW_BYTES);
        rows = fit_size(regs_shadow.frame_rows, DEF_MAX_ROWS);
        for (int unsigned r = 0; r < rows; r++) begin
            case ($urandom_range(3))
                0, 1:    pct = 0;
                2:       pct = 30;
                default: pct = 100;
            endcase
            queue_row(rb, $urandom_range(99) < 8, pct);
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        int unsigned rand_items0;
        int unsigned done;
        int unsigned frames;

        clear_tracker();
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // --- directed: 3-byte rows of 2-byte pixels, two rows per frame
        apply_config(make_cfg(3, 2, 2, 0, 0, 4096, 0, 0));
        queue_row(3, 1'b0, 0);                  // frame without damage
        queue_row(3, 1'b0, 0);
        queue_row(3, 1'b1, 0);                  // forced row, no changed bytes
        push_byte(8'h00, 8'h00, 1'b0);
        push_byte(8'hA5, 8'hA5, 1'b1);          // force ignored off the first byte
        push_byte(8'h00, 8'hFF, 1'b0);          // change in the padding byte
        push_byte(8'hFF, 8'h00, 1'b0);          // byte extremes
        push_byte(8'h00, 8'hFF, 1'b0);
        push_byte(8'hFF, 8'hFF, 1'b0);
        queue_row(3, 1'b0, 0);
        wait_idle();

        // clip band on row 1, empty anim band, forced row outside both
        apply_config(make_cfg(1, 1, 6, 3, 1, 2, 4, 4));
        for (int r = 0; r < 6; r++) queue_row(1, r == 3, 100);
        wait_idle();
        // inverted clip band, anim band rows 0..1
        apply_config(make_cfg(1, 1, 6, 3, 5, 1, 0, 2));
        for (int r = 0; r < 6; r++) queue_row(1, 1'b0, 100);
        wait_idle();
        // anim band not valid: nothing left inside any band
        write_reg(REG_BAND_FLAGS, 1);
        end_writes();
        for (int r = 0; r < 6; r++) queue_row(1, 1'b0, 100);
        wait_idle();

        // zero sizes act as one: every byte is a whole frame
        apply_config(make_cfg(0, 0, 0, 0, 0, 4096, 0, 0));
        push_byte(8'h12, 8'h34, 1'b0);
        push_byte(8'h56, 8'h56, 1'b0);
        wait_idle();

        // oversized pixel size acts as 4: change at byte 5 is pixel 1
        apply_config(make_cfg(8, 7, 1, 0, 0, 4096, 0, 0));
        for (int b = 0; b < 8; b++) push_byte((b == 5) ? 8'h7F : 8'h80, 8'h80, 1'b0);
        wait_idle();

        // shrink row length and frame height in mid-frame
        apply_config(make_cfg(4, 1, 3, 0, 0, 4096, 0, 0));
        queue_row(3, 1'b0, 100);
        wait_idle();
        write_reg(REG_ROW_BYTES, 2);            // byte counter already past: row ends next byte
        end_writes();
        queue_row(1, 1'b0, 0);
        queue_row(2, 1'b0, 0);
        wait_idle();
        write_reg(REG_FRAME_ROWS, 1);           // row counter past: frame ends with this row
        end_writes();
        queue_row(2, 1'b0, 100);
        wait_idle();

        // alternating rows: more runs than rectangle slots, last one absorbs the rest
        apply_config(make_cfg(1, 1, 40, 0, 0, 4096, 0, 0));
        for (int r = 0; r < 40; r++) queue_row(1, 1'b0, (r % 2 == 0) ? 100 : 0);
        wait_idle();

        // --- random frames in three idling phases
        rand_items0 = items_queued;
        frames      = 0;
        while (items_queued - rand_items0 < RANDOM_ITEMS) begin
            done = items_queued - rand_items0;
            if (done >= RANDOM_ITEMS / 3 && send_idle_pct == 35) begin
                wait_idle();
                send_idle_pct = 76;
                recv_idle_pct = 35;
                // stall the receiver long enough that the row queue fills
                // and the input backs up, while bytes keep being offered
                apply_config(make_cfg(2, 1, 3, 0, 0, 4096, 0, 0));
                @(posedge aclk);
                hold_go <= 1'b1;
                @(posedge aclk);
                hold_go <= 1'b0;
                for (int f = 0; f < 4; f++) begin
                    queue_row(2, 1'b0, 100);
                    queue_row(2, 1'b0, 0);
                    queue_row(2, 1'b1, 0);
                end
                wait_idle();
            end else if (done >= 2 * RANDOM_ITEMS / 3 && send_idle_pct == 76) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            if (frames % 3 == 0) begin
                wait_idle();
                apply_config(random_cfg());
            end
            queue_random_frame();
            frames++;
            if ($urandom_range(4) == 0) wait_idle();
        end
        wait_idle();

        // --- register extremes, no idling
        send_idle_pct = 0;
        recv_idle_pct = 0;
        // widest row setting (caps at 8192 bytes), forced; shrunk after six bytes
        // so the row ends on the next byte with a full width of 7
        apply_config(make_cfg(16383, 1, 1, 0, 0, 8191, 0, 0));
        queue_row(6, 1'b1, 50);
        wait_idle();
        write_reg(REG_ROW_BYTES, 7);
        end_writes();
        queue_row(1, 1'b0, 50);
        wait_idle();
        // tallest frame setting (caps at 4096 rows), inverted clip, anim band from row 5
        apply_config(make_cfg(0, 4, 8191, 3, 8191, 0, 5, 8191));
        for (int r = 0; r < 12; r++) queue_row(1, r == 9, (r % 3 == 0) ? 100 : 30);
        wait_idle();
        write_reg(REG_FRAME_ROWS, 1);           // row counter far past: frame ends next row
        end_writes();
        queue_row(1, 1'b0, 100);
        wait_idle();

        $display("Run covered %0d frame bytes over %0d register settings, %0d rectangles checked",
                 bytes_taken, settings_used, rects_checked);
        $display("Predicted %0d rectangles, mismatches: %0d", rects_predicted, error_count);
        if (error_count == 0 && expected_rects.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #(TIMEOUT_NS);
        $display("Timeout: %0d rectangles still expected, %0d bytes not sent",
                 expected_rects.size(), pending_bytes.size());
        $display("*** FAILED ***");
        $finish;
    end

endmodule

### files.f
sv/fdrt_pkg.sv
sv/fdrt_queue.sv
sv/fdrt_front.sv
sv/fdrt_back.sv
sv/frame_damage_rect_tracker.sv
dv/tb_top.sv
